// ----- hdl/led_channel_blink_controller_assert.svh -----
// Assertion macros shared by the controller RTL.
// Depends on nothing; included inside module bodies.
`ifndef LED_CHANNEL_BLINK_CONTROLLER_ASSERT_SVH
`define LED_CHANNEL_BLINK_CONTROLLER_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define LCBC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcbc assertion failed");

// Next-cycle implication, ignored while reset is high.
`define LCBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcbc assertion failed");

`endif

// ----- hdl/lcbc_pkg.sv -----
// Shared types and constants of the LED channel blink controller.
// Depends on nothing; used by lcbc_engine and the top level.
package lcbc_pkg;

   localparam int NUM_CHANNELS     = 8;
   localparam int NUM_PWM_CHANNELS = 3;
   localparam int NUM_LEVELS       = 5;
   localparam int PIN_COUNT        = NUM_CHANNELS - NUM_PWM_CHANNELS;

   localparam int OP_W    = 2;
   localparam int CH_W    = 3;
   localparam int CODE_W  = 2;
   localparam int LVL_W   = 3;
   localparam int DUTY_W  = 10;
   localparam int TICK_W  = 16;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   localparam logic [DUTY_W-1:0] DUTY_RESET   = 10'd500;
   localparam logic [TICK_W-1:0] PERIOD_RESET = 16'd100;
   localparam logic [TICK_W-1:0] ON_RESET     = 16'd50;
   localparam logic [NUM_LEVELS-1:0][DUTY_W-1:0] LEVEL_RESET =
      {10'd1000, 10'd600, 10'd500, 10'd400, 10'd200};

   typedef enum logic [OP_W-1:0] {
      OP_SET_STATE = 2'd0,
      OP_SET_LEVEL = 2'd1,
      OP_TICK      = 2'd2,
      OP_APPLY     = 2'd3
   } lcbc_op_type;

   typedef enum logic [CODE_W-1:0] {
      CODE_OFF    = 2'd0,
      CODE_ON     = 2'd1,
      CODE_BLINK  = 2'd2,
      CODE_TOGGLE = 2'd3
   } lcbc_code_type;

   typedef enum logic [2:0] {
      REG_PERIOD   = 3'd0,
      REG_ON_TICKS = 3'd1,
      REG_LEVEL0   = 3'd2,
      REG_LEVEL1   = 3'd3,
      REG_LEVEL2   = 3'd4,
      REG_LEVEL3   = 3'd5,
      REG_LEVEL4   = 3'd6
   } lcbc_reg_type;

   typedef struct packed {
      lcbc_op_type        op;
      logic [CH_W-1:0]    channel;
      lcbc_code_type      state_code;
      logic [LVL_W-1:0]   level_index;
   } lcbc_cmd_type;

   typedef struct packed {
      logic [TICK_W-1:0]                    period;
      logic [TICK_W-1:0]                    on_ticks;
      logic [NUM_LEVELS-1:0][DUTY_W-1:0]    level_duty;
   } lcbc_cfg_type;

   typedef struct packed {
      logic [NUM_CHANNELS-1:0]                  on_req;
      logic [NUM_CHANNELS-1:0]                  blink_req;
      logic                                     phase;
      logic [TICK_W-1:0]                        tick;
      logic [NUM_PWM_CHANNELS-1:0][DUTY_W-1:0]  chan_duty;
      logic [NUM_PWM_CHANNELS-1:0][DUTY_W-1:0]  app_duty;
      logic [PIN_COUNT-1:0]                     app_pins;
   } lcbc_state_type;

endpackage

// ----- hdl/lcbc_engine.sv -----
// Channel state registers and the single-pass update for one request.
// Depends on lcbc_pkg.
module lcbc_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  lcbc_pkg::lcbc_cmd_type cmd,
   input  lcbc_pkg::lcbc_cfg_type cfg,
   output lcbc_pkg::lcbc_state_type nxt
);
   import lcbc_pkg::*;

   lcbc_state_type           state_ff;
   lcbc_state_type           state_in;
   logic [NUM_CHANNELS-1:0]  drv_en;
   logic [NUM_CHANNELS-1:0]  drv_hi;
   logic [TICK_W-1:0]        tick_inc;

   assign tick_inc = TICK_W'(state_ff.tick + 1'b1);

   always_comb begin
      state_in = state_ff;
      drv_en   = '0;
      drv_hi   = '0;
      case (cmd.op)
         OP_SET_STATE: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (cmd.channel == CH_W'(i)) begin
                  case (cmd.state_code)
                     CODE_ON: begin
                        state_in.blink_req[i] = 1'b0;
                        state_in.on_req[i]    = 1'b1;
                        drv_en[i]             = 1'b1;
                        drv_hi[i]             = 1'b1;
                     end
                     CODE_BLINK: begin
                        state_in.blink_req[i] = 1'b1;
                     end
                     CODE_TOGGLE: begin
                        state_in.on_req[i] = ~state_ff.on_req[i];
                        drv_en[i]          = 1'b1;
                        drv_hi[i]          = ~state_ff.on_req[i];
                     end
                     default: begin
                        // off: clear the on request; a blinking channel also drops its blink request, others drive low
                        state_in.on_req[i] = 1'b0;
                        if (state_ff.blink_req[i]) begin
                           state_in.blink_req[i] = 1'b0;
                        end else begin
                           drv_en[i] = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         OP_SET_LEVEL: begin
            for (int p = 0; p < NUM_PWM_CHANNELS; p++) begin
               for (int l = 0; l < NUM_LEVELS; l++) begin
                  if (cmd.channel == CH_W'(p) && cmd.level_index == LVL_W'(l)) begin
                     state_in.chan_duty[p] = cfg.level_duty[l];
                  end
               end
            end
         end
         OP_TICK: begin
            if (state_ff.blink_req != '0) begin
               state_in.tick = tick_inc;
               if (tick_inc >= cfg.period) begin
                  state_in.phase = 1'b1;
                  state_in.tick  = '0;
               end else if (tick_inc == cfg.on_ticks) begin
                  state_in.phase = 1'b0;
               end
            end else begin
               state_in.tick = '0;
            end
         end
         default: begin
            // apply: push the shared phase to every blinking channel
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (state_ff.blink_req[i]) begin
                  state_in.on_req[i] = state_ff.phase;
                  drv_en[i]          = 1'b1;
                  drv_hi[i]          = state_ff.phase;
               end
            end
         end
      endcase

      for (int p = 0; p < NUM_PWM_CHANNELS; p++) begin
         if (drv_en[p]) begin
            state_in.app_duty[p] = drv_hi[p] ? state_ff.chan_duty[p] : '0;
         end
      end
      for (int k = 0; k < PIN_COUNT; k++) begin
         if (drv_en[NUM_PWM_CHANNELS+k]) begin
            state_in.app_pins[k] = drv_hi[NUM_PWM_CHANNELS+k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.on_req    <= '0;
         state_ff.blink_req <= '0;
         state_ff.phase     <= 1'b0;
         state_ff.tick      <= '0;
         for (int p = 0; p < NUM_PWM_CHANNELS; p++) begin
            state_ff.chan_duty[p] <= DUTY_RESET;
         end
         state_ff.app_duty  <= '0;
         state_ff.app_pins  <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   assign nxt = state_in;

endmodule

// ----- hdl/led_channel_blink_controller.sv -----
// Top level of the LED channel blink controller: request stage, result
// register and control/status registers. Depends on lcbc_pkg, lcbc_engine
// and led_channel_blink_controller_assert.svh.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------------
//   req     | req_valid/req_stall | opcode, channel, state_code, level_index
//   rsp     | rsp_valid/rsp_stall | duty_out0..2, pin_levels, on_mask, phase_on
//   csr     | APB psel/penable    | paddr (byte, 4 per register), pwdata, prdata
//
// One request per cycle is sustained while rsp_stall is low; an accepted
// request passes through the request register, then the result register,
// where its result is presented.
// The request register doubles as a skid slot: while a result waits under
// rsp_stall, one more request is still taken, then req_stall rises.
// Reset (synchronous, high) clears channel state, blink counter and both
// valid flags, and loads the documented register defaults.
module led_channel_blink_controller (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [lcbc_pkg::OP_W-1:0]        req_opcode,
   input  logic [lcbc_pkg::CH_W-1:0]        req_channel,
   input  logic [lcbc_pkg::CODE_W-1:0]      req_state_code,
   input  logic [lcbc_pkg::LVL_W-1:0]       req_level_index,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [lcbc_pkg::DUTY_W-1:0]      rsp_duty_out0,
   output logic [lcbc_pkg::DUTY_W-1:0]      rsp_duty_out1,
   output logic [lcbc_pkg::DUTY_W-1:0]      rsp_duty_out2,
   output logic [lcbc_pkg::PIN_COUNT-1:0]   rsp_pin_levels,
   output logic [lcbc_pkg::NUM_CHANNELS-1:0] rsp_on_mask,
   output logic                             rsp_phase_on,

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lcbc_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [lcbc_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [lcbc_pkg::DATA_W-1:0]      csr_prdata,
   output logic                             csr_pready
);
   import lcbc_pkg::*;
   `include "led_channel_blink_controller_assert.svh"

   // ---------------------------------------------------------------------
   // Control/status registers
   // ---------------------------------------------------------------------
   lcbc_cfg_type  cfg_ff;
   lcbc_reg_type  csr_index;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = lcbc_reg_type'(csr_paddr[ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period     <= PERIOD_RESET;
         cfg_ff.on_ticks   <= ON_RESET;
         cfg_ff.level_duty <= LEVEL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_PERIOD:   cfg_ff.period        <= csr_pwdata[TICK_W-1:0];
            REG_ON_TICKS: cfg_ff.on_ticks      <= csr_pwdata[TICK_W-1:0];
            REG_LEVEL0:   cfg_ff.level_duty[0] <= csr_pwdata[DUTY_W-1:0];
            REG_LEVEL1:   cfg_ff.level_duty[1] <= csr_pwdata[DUTY_W-1:0];
            REG_LEVEL2:   cfg_ff.level_duty[2] <= csr_pwdata[DUTY_W-1:0];
            REG_LEVEL3:   cfg_ff.level_duty[3] <= csr_pwdata[DUTY_W-1:0];
            REG_LEVEL4:   cfg_ff.level_duty[4] <= csr_pwdata[DUTY_W-1:0];
            default: ;    // drop writes past the last register
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PERIOD:   csr_prdata = DATA_W'(cfg_ff.period);
         REG_ON_TICKS: csr_prdata = DATA_W'(cfg_ff.on_ticks);
         REG_LEVEL0:   csr_prdata = DATA_W'(cfg_ff.level_duty[0]);
         REG_LEVEL1:   csr_prdata = DATA_W'(cfg_ff.level_duty[1]);
         REG_LEVEL2:   csr_prdata = DATA_W'(cfg_ff.level_duty[2]);
         REG_LEVEL3:   csr_prdata = DATA_W'(cfg_ff.level_duty[3]);
         REG_LEVEL4:   csr_prdata = DATA_W'(cfg_ff.level_duty[4]);
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Request register
   // ---------------------------------------------------------------------
   logic          in_valid_ff;
   lcbc_cmd_type  in_cmd_ff;
   logic          out_free;
   logic          advance;
   logic          req_take;

   // result slot is free when empty or being drained this cycle
   assign out_free  = !rsp_valid || !rsp_stall;
   // move the held request into the engine and the result register
   assign advance   = in_valid_ff && out_free;
   // hold the request stage only when it is full and cannot move
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff.op          <= lcbc_op_type'(req_opcode);
         in_cmd_ff.channel     <= req_channel;
         in_cmd_ff.state_code  <= lcbc_code_type'(req_state_code);
         in_cmd_ff.level_index <= req_level_index;
      end
   end

   // ---------------------------------------------------------------------
   // Channel state update
   // ---------------------------------------------------------------------
   lcbc_state_type nxt;

   lcbc_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .cmd   (in_cmd_ff),
      .cfg   (cfg_ff),
      .nxt   (nxt)
   );

   // ---------------------------------------------------------------------
   // Result register: snapshot of the state after the update
   // ---------------------------------------------------------------------
   logic                          rsp_valid_ff;
   logic [DUTY_W-1:0]             duty0_ff;
   logic [DUTY_W-1:0]             duty1_ff;
   logic [DUTY_W-1:0]             duty2_ff;
   logic [PIN_COUNT-1:0]          pins_ff;
   logic [NUM_CHANNELS-1:0]       on_mask_ff;
   logic                          phase_ff;
   logic                          rsp_valid_in;

   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         duty0_ff   <= nxt.app_duty[0];
         duty1_ff   <= nxt.app_duty[1];
         duty2_ff   <= nxt.app_duty[2];
         pins_ff    <= nxt.app_pins;
         on_mask_ff <= nxt.on_req;
         phase_ff   <= nxt.phase;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_duty_out0  = duty0_ff;
   assign rsp_duty_out1  = duty1_ff;
   assign rsp_duty_out2  = duty2_ff;
   assign rsp_pin_levels = pins_ff;
   assign rsp_on_mask    = on_mask_ff;
   assign rsp_phase_on   = phase_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `LCBC_ASSERT_NOW(a_no_stall_when_empty, clock, reset, !rsp_valid_ff, !req_stall)
   `LCBC_ASSERT_NEXT(a_advance_fills_result, clock, reset, advance, rsp_valid_ff)
   `LCBC_ASSERT_NEXT(a_held_request_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `LCBC_ASSERT_NEXT(a_drain_empties_result, clock, reset,
      rsp_valid_ff && !rsp_stall && !advance, !rsp_valid_ff)

endmodule
